>>> sv/tic_pkg.sv
package tic_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int ADC_BITS_DEF = 10;

    localparam int CHANNEL_W = 2;
    localparam int SAMPLE_W  = 10;
    localparam int TRIM_W    = 16;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CENTRE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRACK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MID  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW  = 2'd3;

    localparam logic signed [TRIM_W-1:0] HIGH_RST = 16'sd100;
    localparam logic signed [TRIM_W-1:0] MID_RST  = 16'sd0;
    localparam logic signed [TRIM_W-1:0] LOW_RST  = -16'sd100;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_CAPTURE,
        ST_TRACK
    } t_store_op;

endpackage

>>> sv/tic_in_if.sv
interface tic_in_if;
    import tic_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHANNEL_W-1:0] channel;
    logic [SAMPLE_W-1:0]  sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

>>> sv/tic_out_if.sv
interface tic_out_if;
    import tic_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CHANNEL_W-1:0]     out_channel;
    logic signed [TRIM_W-1:0] trim_value;

    modport source (output valid, output out_channel, output trim_value, input ready);
    modport sink   (input valid, input out_channel, input trim_value, output ready);
endinterface

>>> sv/trim_input_calibration_unit.sv
// Trim input calibration: per-channel minimum, centre and maximum points.
// Capture and track samples update the stores and are taken back to back, one per cycle.
// A mapped sample goes through prepare, multiply, divide (one quotient bit per cycle),
// saturate and output; a centre or zero-span sample goes from prepare to output.
// A new sample is taken only back in idle, so a stalled result holds the input off.
// Synchronous active-low reset restores the state, mode, limits and stored points.
module trim_input_calibration_unit #(
    parameter int CHANNELS = tic_pkg::CHANNELS_DEF,
    parameter int ADC_BITS = tic_pkg::ADC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tic_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tic_pkg::TRIM_W-1:0]     i_cfg_data,
    tic_in_if.sink                         i_in,
    tic_out_if.source                      o_out
);
    import tic_pkg::*;

    localparam int PW = ADC_BITS + TRIM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV,
        S_SAT,
        S_OUT
    } t_state;

    t_state                   r_state;
    logic [MODE_W-1:0]        r_mode;
    logic signed [TRIM_W-1:0] r_high;
    logic signed [TRIM_W-1:0] r_mid;
    logic signed [TRIM_W-1:0] r_low;
    logic [CHANNEL_W-1:0]     r_ch;
    logic [ADC_BITS-1:0]      r_s;
    logic [ADC_BITS-1:0]      r_mag_d;
    logic [TRIM_W-1:0]        r_mag_diff;
    logic [ADC_BITS-1:0]      r_den;
    logic                     r_neg;
    logic [PW-1:0]            r_prod;
    logic                     r_div_start;
    logic signed [TRIM_W-1:0] r_res;
    logic                     r_out_valid;
    logic [CHANNEL_W-1:0]     r_out_ch;
    logic signed [TRIM_W-1:0] r_out_val;

    logic [ADC_BITS+SAMPLE_W-1:0] s_ext;
    logic [ADC_BITS-1:0]          s_in;
    logic                         accept;
    logic                         in_range;
    logic                         mode_map;
    t_store_op                    store_op;
    logic [CHANNEL_W-1:0]         store_ch;
    logic [ADC_BITS-1:0]          st_min;
    logic [ADC_BITS-1:0]          st_centre;
    logic [ADC_BITS-1:0]          st_max;

    logic                     gt;
    logic                     lt;
    logic [ADC_BITS-1:0]      mag_d;
    logic [ADC_BITS-1:0]      den;
    logic signed [TRIM_W:0]   span_hm;
    logic signed [TRIM_W:0]   span_ml;
    logic signed [TRIM_W:0]   span;
    logic [TRIM_W:0]          mag_span;

    logic                     div_done;
    logic [PW-1:0]            div_quot;
    logic [TRIM_W:0]          q_clip;
    logic signed [TRIM_W+2:0] sum;
    logic signed [TRIM_W-1:0] sat_val;

    assign s_ext    = {{ADC_BITS{1'b0}}, i_in.sample};
    assign s_in     = s_ext[ADC_BITS-1:0];
    assign accept   = i_in.valid && i_in.ready;
    assign in_range = (32'(i_in.channel) < CHANNELS);
    assign mode_map = (r_mode != MODE_CENTRE) && (r_mode != MODE_TRACK);

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        store_op = ST_NONE;
        if (accept && in_range) begin
            if (r_mode == MODE_CENTRE) begin
                store_op = ST_CAPTURE;
            end else if (r_mode == MODE_TRACK) begin
                store_op = ST_TRACK;
            end
        end
    end

    // The stores are addressed by the incoming channel while idle and by the
    // held channel while a mapped sample is in flight.
    assign store_ch = (r_state == S_IDLE) ? i_in.channel : r_ch;

    tic_store #(
        .CHANNELS (CHANNELS),
        .ADC_BITS (ADC_BITS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (store_op),
        .i_ch     (store_ch),
        .i_sample (s_in),
        .o_min    (st_min),
        .o_centre (st_centre),
        .o_max    (st_max)
    );

    // Sign and magnitude of the offset from centre and of the output span.
    always_comb begin
        gt       = (r_s > st_centre);
        lt       = (r_s < st_centre);
        mag_d    = gt ? (r_s - st_centre) : (st_centre - r_s);
        den      = gt ? (st_max - st_centre) : (st_centre - st_min);
        span_hm  = {r_high[TRIM_W-1], r_high} - {r_mid[TRIM_W-1], r_mid};
        span_ml  = {r_mid[TRIM_W-1], r_mid} - {r_low[TRIM_W-1], r_low};
        span     = gt ? span_hm : span_ml;
        mag_span = span[TRIM_W] ? $unsigned(-span) : $unsigned(span);
    end

    tic_div #(
        .ADC_BITS (ADC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // A quotient beyond 17 bits saturates just as its clipped value does.
    always_comb begin
        q_clip = (|div_quot[PW-1:TRIM_W+1]) ? '1 : div_quot[TRIM_W:0];
        if (r_neg) begin
            sum = {{3{r_mid[TRIM_W-1]}}, r_mid} - $signed({2'b00, q_clip});
        end else begin
            sum = {{3{r_mid[TRIM_W-1]}}, r_mid} + $signed({2'b00, q_clip});
        end
        if (sum > 19'sd32767) begin
            sat_val = 16'sh7FFF;
        end else if (sum < -19'sd32768) begin
            sat_val = 16'sh8000;
        end else begin
            sat_val = sum[TRIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_NORMAL;
            r_high      <= HIGH_RST;
            r_mid       <= MID_RST;
            r_low       <= LOW_RST;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_MUL);

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MODE: r_mode <= i_cfg_data[MODE_W-1:0];
                    REG_HIGH: r_high <= i_cfg_data;
                    REG_MID:  r_mid  <= i_cfg_data;
                    REG_LOW:  r_low  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && o_out.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept && in_range && mode_map) begin
                        r_ch    <= i_in.channel;
                        r_s     <= s_in;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_mag_d    <= mag_d;
                    r_mag_diff <= mag_span[TRIM_W-1:0];
                    r_den      <= den;
                    r_neg      <= lt ^ span[TRIM_W];
                    if (!gt && !lt) begin
                        r_res   <= r_mid;
                        r_state <= S_OUT;
                    end else if (den == '0) begin
                        r_res   <= gt ? r_high : r_low;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod      <= {{TRIM_W{1'b0}}, r_mag_d} * {{ADC_BITS{1'b0}}, r_mag_diff};
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    r_res   <= sat_val;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_ch    <= r_ch;
                        r_out_val   <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_channel = r_out_ch;
    assign o_out.trim_value  = r_out_val;

`ifndef SYNTHESIS
    a_store_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP) |-> ((st_min <= st_centre) && (st_centre <= st_max)))
        else $error("calibration points out of order");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> ((r_state == S_DIV) && !div_done))
        else $error("divider started outside the divide state");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && (!r_out_valid || o_out.ready))
        |=> (o_out.valid && (r_state == S_IDLE)))
        else $error("result not loaded into the output register");
`endif

endmodule

>>> sv/tic_store.sv
module tic_store #(
    parameter int CHANNELS = tic_pkg::CHANNELS_DEF,
    parameter int ADC_BITS = tic_pkg::ADC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tic_pkg::t_store_op             i_op,
    input  logic [tic_pkg::CHANNEL_W-1:0]  i_ch,
    input  logic [ADC_BITS-1:0]            i_sample,
    output logic [ADC_BITS-1:0]            o_min,
    output logic [ADC_BITS-1:0]            o_centre,
    output logic [ADC_BITS-1:0]            o_max
);
    import tic_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;
    localparam logic [ADC_BITS-1:0] CENTRE_RST = FULL_SCALE >> 1;

    logic [ADC_BITS-1:0] r_min    [CHANNELS];
    logic [ADC_BITS-1:0] r_centre [CHANNELS];
    logic [ADC_BITS-1:0] r_max    [CHANNELS];

    logic [CH_W+CHANNEL_W-1:0] ch_ext;
    logic [CH_W-1:0]           idx;

    assign ch_ext = {{CH_W{1'b0}}, i_ch};
    assign idx    = ch_ext[CH_W-1:0];

    assign o_min    = r_min[idx];
    assign o_centre = r_centre[idx];
    assign o_max    = r_max[idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_min[i]    <= '0;
                r_centre[i] <= CENTRE_RST;
                r_max[i]    <= FULL_SCALE;
            end
        end else begin
            unique case (i_op)
                ST_CAPTURE: begin
                    r_min[idx]    <= i_sample;
                    r_centre[idx] <= i_sample;
                    r_max[idx]    <= i_sample;
                end
                ST_TRACK: begin
                    // Only one end moves per sample, the lower end first.
                    if (i_sample < o_min) begin
                        r_min[idx] <= i_sample;
                    end else if (i_sample > o_max) begin
                        r_max[idx] <= i_sample;
                    end
                end
                ST_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> sv/tic_div.sv
module tic_div #(
    parameter int ADC_BITS = tic_pkg::ADC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [ADC_BITS+tic_pkg::TRIM_W-1:0]  i_dividend,
    input  logic [ADC_BITS-1:0]                  i_divisor,
    output logic                                 o_done,
    output logic [ADC_BITS+tic_pkg::TRIM_W-1:0]  o_quot
);
    import tic_pkg::*;

    localparam int PW    = ADC_BITS + TRIM_W;
    localparam int CNT_W = $clog2(PW + 1);

    logic [PW-1:0]       r_work;
    logic [ADC_BITS-1:0] r_rem;
    logic [ADC_BITS-1:0] r_den;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [PW-1:0]       n_work;
    logic [ADC_BITS-1:0] n_rem;
    logic [ADC_BITS:0]   rem_sh;
    logic [ADC_BITS:0]   rem_sub;
    logic                fits;

    // Restoring division: the dividend shifts out at the top of r_work while
    // the quotient bits shift in at the bottom.
    always_comb begin
        rem_sh  = {r_rem, r_work[PW-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        fits    = (rem_sh >= {1'b0, r_den});
        n_rem   = fits ? rem_sub[ADC_BITS-1:0] : rem_sh[ADC_BITS-1:0];
        n_work  = {r_work[PW-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_work <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
                r_cnt  <= CNT_W'(PW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_work <= n_work;
                r_rem  <= n_rem;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_work;

endmodule

>>> tb/trim_input_calibration_checker.sv
module trim_input_calibration_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tic_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tic_pkg::TRIM_W-1:0]    i_cfg_data,
    tic_in_if                             i_in_mon,
    tic_out_if                            i_out_mon,
    output int                            o_mismatches,
    output int                            o_pending
);
    import tic_pkg::*;

    localparam longint TRIM_MAX   = 2 ** (TRIM_W - 1) - 1;
    localparam longint TRIM_MIN   = -(2 ** (TRIM_W - 1));
    localparam logic [SAMPLE_W-1:0] ADC_FULL = '1;

    typedef struct packed {
        logic [CHANNEL_W-1:0]     channel;
        logic signed [TRIM_W-1:0] value;
    } trim_result_t;

    logic [MODE_W-1:0]        cal_mode;
    logic signed [TRIM_W-1:0] lim_high;
    logic signed [TRIM_W-1:0] mid_val;
    logic signed [TRIM_W-1:0] lim_low;
    logic [SAMPLE_W-1:0]      min_pt    [CHANNELS_DEF];
    logic [SAMPLE_W-1:0]      centre_pt [CHANNELS_DEF];
    logic [SAMPLE_W-1:0]      max_pt    [CHANNELS_DEF];
    trim_result_t             trim_expect_q [$];
    int                       mismatches = 0;

    assign o_mismatches = mismatches;

    // Piecewise-linear mapping of one sample against the stored points of its channel.
    function automatic logic signed [TRIM_W-1:0] scale_sample(
        input logic [CHANNEL_W-1:0] ch,
        input logic [SAMPLE_W-1:0]  s
    );
        longint c;
        longint d;
        longint den;
        longint sum;
        c   = longint'(centre_pt[ch]);
        d   = longint'(s) - c;
        if (d == 0) begin
            return mid_val;
        end
        if (d > 0) begin
            den = longint'(max_pt[ch]) - c;
            if (den == 0) begin
                return lim_high;
            end
            sum = longint'(mid_val) + (d * (longint'(lim_high) - longint'(mid_val))) / den;
        end else begin
            den = c - longint'(min_pt[ch]);
            if (den == 0) begin
                return lim_low;
            end
            sum = longint'(mid_val) + (d * (longint'(mid_val) - longint'(lim_low))) / den;
        end
        if (sum > TRIM_MAX) begin
            sum = TRIM_MAX;
        end else if (sum < TRIM_MIN) begin
            sum = TRIM_MIN;
        end
        return sum[TRIM_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : track_block
        trim_result_t         want;
        logic [CHANNEL_W-1:0] ch;
        logic [SAMPLE_W-1:0]  s;
        if (!i_rst_n) begin
            cal_mode = MODE_NORMAL;
            lim_high = HIGH_RST;
            mid_val  = MID_RST;
            lim_low  = LOW_RST;
            for (int k = 0; k < CHANNELS_DEF; k++) begin
                min_pt[k]    = '0;
                centre_pt[k] = ADC_FULL >> 1;
                max_pt[k]    = ADC_FULL;
            end
            trim_expect_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MODE: cal_mode = i_cfg_data[MODE_W-1:0];
                    REG_HIGH: lim_high = i_cfg_data;
                    REG_MID:  mid_val  = i_cfg_data;
                    REG_LOW:  lim_low  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (trim_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction: channel %0d value %0d",
                                              i_out_mon.out_channel, i_out_mon.trim_value));
                end else begin
                    want = trim_expect_q.pop_front();
                    if (i_out_mon.out_channel !== want.channel) begin
                        report_mismatch($sformatf("out_channel %0d, expected %0d",
                                                  i_out_mon.out_channel, want.channel));
                    end
                    if (i_out_mon.trim_value !== want.value) begin
                        report_mismatch($sformatf("trim_value %0d on channel %0d, expected %0d",
                                                  i_out_mon.trim_value, want.channel,
                                                  want.value));
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                ch = i_in_mon.channel;
                s  = i_in_mon.sample;
                case (cal_mode)
                    MODE_CENTRE: begin
                        min_pt[ch]    = s;
                        centre_pt[ch] = s;
                        max_pt[ch]    = s;
                    end
                    MODE_TRACK: begin
                        if (s < min_pt[ch]) begin
                            min_pt[ch] = s;
                        end else if (s > max_pt[ch]) begin
                            max_pt[ch] = s;
                        end
                    end
                    default: begin
                        // The unused mode code maps like normal mode.
                        want.channel = ch;
                        want.value   = scale_sample(ch, s);
                        trim_expect_q.push_back(want);
                    end
                endcase
            end
        end
        o_pending <= trim_expect_q.size();
    end
endmodule

>>> tb/trim_input_calibration_unit_test.sv
module trim_input_calibration_unit_test;
    import tic_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 600;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_GAP       = 13;
    localparam int RUN_LIMIT     = 10_000_000;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [TRIM_W-1:0] TRIM_TOP   = 16'h7FFF;
    localparam logic [TRIM_W-1:0] TRIM_BOT   = 16'h8000;
    localparam logic [SAMPLE_W-1:0] ADC_TOP  = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [TRIM_W-1:0]    cfg_data;
    int                   mismatches;
    int                   pending;
    bit                   fast_phase = 1'b0;
    bit                   rx_hold = 1'b0;
    int                   items_sent = 0;

    tic_in_if  sample_ch ();
    tic_out_if trim_ch ();

    trim_input_calibration_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (sample_ch),
        .o_out      (trim_ch)
    );

    trim_input_calibration_checker calib_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_mon     (sample_ch),
        .i_out_mon    (trim_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    initial begin
        #RUN_LIMIT;
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off when the stimulus asks for it.
    initial begin : result_sink
        int gap;
        trim_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (rx_hold) begin
                gap     = HOLD_CYCLES;
                rx_hold = 1'b0;
            end else begin
                gap = fast_phase ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                trim_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            trim_ch.ready <= 1'b1;
            do @(posedge clk); while (!(trim_ch.valid && trim_ch.ready));
        end
    end

    function automatic logic [TRIM_W-1:0] draw_trim();
        case ($urandom_range(0, 5))
            0:       return TRIM_TOP;
            1:       return TRIM_BOT;
            2, 3:    return TRIM_W'($signed($urandom_range(0, 400)) - 200);
            default: return TRIM_W'($urandom());
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ADC_TOP;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic send_sample(input logic [CHANNEL_W-1:0] ch, input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = fast_phase ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.channel <= ch;
        sample_ch.sample  <= s;
        do @(posedge clk); while (!sample_ch.ready);
        items_sent++;
    endtask

    task automatic send_batch(input int n);
        repeat (n) send_sample(CHANNEL_W'($urandom_range(0, CHANNELS_DEF - 1)), draw_sample());
    endtask

    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Samples in capture or track mode give no result, so the block gets extra time
    // to finish its last transaction before any register changes.
    task automatic set_config(input logic [MODE_W-1:0] m, input logic [TRIM_W-1:0] hi,
                              input logic [TRIM_W-1:0] mid, input logic [TRIM_W-1:0] lo);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_MODE;
        cfg_data <= TRIM_W'(m);
        @(posedge clk);
        cfg_idx  <= REG_HIGH;
        cfg_data <= hi;
        @(posedge clk);
        cfg_idx  <= REG_MID;
        cfg_data <= mid;
        @(posedge clk);
        cfg_idx  <= REG_LOW;
        cfg_data <= lo;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        int round;
        int n;
        int start;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= REG_MODE;
        cfg_data          <= '0;
        sample_ch.valid   <= 1'b0;
        sample_ch.channel <= '0;
        sample_ch.sample  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset calibration: both ends, centre, and truncation toward zero just above and below it.
        send_sample(0, 0);
        send_sample(1, ADC_TOP);
        send_sample(2, 511);
        send_sample(3, 512);
        send_sample(0, 510);

        set_config(MODE_CENTRE, 16'sd1000, 16'sd10, -16'sd1000);
        send_sample(0, 300);
        send_sample(1, 0);
        send_sample(2, ADC_TOP);
        send_sample(3, 512);

        // Every span is now zero on the captured channels.
        set_config(MODE_NORMAL, 16'sd1000, 16'sd10, -16'sd1000);
        send_sample(0, 300);
        send_sample(0, 301);
        send_sample(0, 299);
        send_sample(1, 0);
        send_sample(2, ADC_TOP - 1'b1);

        set_config(MODE_TRACK, 16'sd1000, 16'sd10, -16'sd1000);
        send_sample(0, 100);
        send_sample(0, 900);
        send_sample(0, 500);

        // Extreme limits: a sample past the stored maximum overflows in both directions.
        set_config(MODE_SPARE, TRIM_TOP, TRIM_BOT, TRIM_TOP);
        send_sample(0, ADC_TOP);
        send_sample(0, 0);
        send_sample(3, ADC_TOP);
        set_config(MODE_NORMAL, TRIM_BOT, TRIM_TOP, TRIM_BOT);
        send_sample(0, ADC_TOP);

        start = items_sent;
        round = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            fast_phase = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 1) begin
                set_config(MODE_CENTRE, draw_trim(), draw_trim(), draw_trim());
                send_batch($urandom_range(4, 8));
                set_config(MODE_TRACK, draw_trim(), draw_trim(), draw_trim());
                send_batch($urandom_range(4, 12));
            end else if ($urandom_range(0, 2) == 0) begin
                set_config(MODE_TRACK, draw_trim(), draw_trim(), draw_trim());
                send_batch($urandom_range(4, 10));
            end
            set_config(($urandom_range(0, 4) == 0) ? MODE_SPARE : MODE_NORMAL,
                       draw_trim(), draw_trim(), draw_trim());
            if (round % 4 == 1) begin
                rx_hold = 1'b1;
            end
            n = $urandom_range(20, 50);
            send_batch(n / 2);
            if (round % 4 == 3) begin
                drain_results();
            end
            send_batch(n - n / 2);
            round++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
